// ----- hw/rtl/bilinear_texture_sampler_defines.svh -----
// Assertion macros used by the checker file of the texture sampler.
`ifndef BILINEAR_TEXTURE_SAMPLER_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/bts_pkg.sv -----
// Constants, register codes and helper functions of the texture sampler.
package bts_pkg;

	localparam int MAX_SIDE_LOG2   = 6;
	localparam int COORD_FRAC_BITS = 16;

	// Fixed field widths of the ports
	localparam int COORD_W   = 20;
	localparam int ADDR_IN_W = 12;
	localparam int TEXEL_W   = 32;
	localparam int CHAN_W    = 8;
	localparam int NUM_CH    = 4;
	localparam int LOG2_W    = 3;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;

	// Texture store geometry
	localparam int SIDE_W      = MAX_SIDE_LOG2;
	localparam int SIDE_LG_W   = $clog2(MAX_SIDE_LOG2 + 1);
	localparam int STORE_AW    = 2 * MAX_SIDE_LOG2;
	localparam int STORE_DEPTH = 1 << STORE_AW;

	// Scaled coordinate: integer part wide enough for the sign and any side
	localparam int INT_A   = COORD_W + MAX_SIDE_LOG2 + 2 - COORD_FRAC_BITS;
	localparam int INT_W   = (INT_A > MAX_SIDE_LOG2 + 2) ? INT_A : MAX_SIDE_LOG2 + 2;
	localparam int S_W     = INT_W + COORD_FRAC_BITS;
	localparam int NEIGH_W = INT_W + 1;

	// Weights
	localparam int WFRAC_W     = COORD_FRAC_BITS + 1;
	localparam int PROD_W      = 2 * COORD_FRAC_BITS + 1;
	localparam int WT_W        = 9;
	localparam int ROUND_SHIFT = 2 * COORD_FRAC_BITS - 8;
	localparam int ACC_W       = CHAN_W + WT_W + 2;
	localparam int BLEND_SHIFT = 8;

	// Sequencer
	localparam int NUM_TAPS = 4;
	localparam int TAP_W    = $clog2(NUM_TAPS);
	localparam int STEP_W   = $clog2(NUM_TAPS + 1);

	localparam logic [S_W-1:0] HALF_TEXEL = S_W'(1) << (COORD_FRAC_BITS - 1);
	localparam logic [WFRAC_W-1:0] ONE_FRAC = WFRAC_W'(1) << COORD_FRAC_BITS;

	// Reset values of the registers
	localparam logic [LOG2_W-1:0] RST_SIDE_LOG2 = LOG2_W'(6);

	typedef enum logic [2:0] {
		REG_WIDTH_LOG2  = 3'd0,
		REG_HEIGHT_LOG2 = 3'd1,
		REG_REPEAT_S    = 3'd2,
		REG_REPEAT_T    = 3'd3,
		REG_LINEAR      = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	// Saturate a side log2 to the store's largest side
	function automatic logic [SIDE_LG_W-1:0] eff_log2(input logic [LOG2_W-1:0] lg);
		if (int'(lg) > MAX_SIDE_LOG2)
			eff_log2 = SIDE_LG_W'(MAX_SIDE_LOG2);
		else
			eff_log2 = SIDE_LG_W'(lg);
	endfunction

	// Wrap by mask (repeat) or clamp to edge along one axis
	function automatic logic [SIDE_W-1:0] wrap_axis(
		input logic signed [NEIGH_W-1:0] t,
		input logic [SIDE_LG_W-1:0] lg,
		input logic rep
	);
		logic [SIDE_W:0] span;
		logic [SIDE_W-1:0] top;
		span = (SIDE_W + 1)'(1) << lg;
		top  = SIDE_W'(span - 1'b1);
		if (rep)
			wrap_axis = t[SIDE_W-1:0] & top;
		else if (t < 0)
			wrap_axis = '0;
		else if (t > $signed({{(NEIGH_W - SIDE_W){1'b0}}, top}))
			wrap_axis = top;
		else
			wrap_axis = t[SIDE_W-1:0];
	endfunction

	// Scale a fraction product to an 8-fraction-bit weight, rounding half up
	function automatic logic [WT_W-1:0] round_weight(input logic [PROD_W-1:0] p);
		logic [PROD_W-1:0] r;
		r = p + (PROD_W'(1) << (ROUND_SHIFT - 1));
		round_weight = r[ROUND_SHIFT +: WT_W];
	endfunction

endpackage

// ----- hw/rtl/bilinear_texture_sampler.sv -----
// Top level of the bilinear / nearest texture sampler with its texel store.
//
//  Channel  | Handshake                     | Payload
//  ---------+-------------------------------+---------------------------------------
//  item     | item_valid / item_ready       | operation, texel_address, texel_value,
//           |                               | coord_u, coord_v
//  result   | result_valid / result_ready   | alpha, red, green, blue
//  config   | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
//  A texel write leaves the sequencer idle; the next transaction can be taken in the cycle after.
//  A bilinear sample fetches its four neighbor texels one per cycle from the single-port
//  store, and its four weights come one per cycle from the one shared fraction
//  multiplier; a nearest sample fetches only the first neighbor.
//  item_ready is high only while the sequencer is idle. A result waits in an output
//  register, so a new transaction is taken while the previous result is stalled;
//  the next sample then holds in its final step until that register is free.
//  Reset (arst_n low) clears the sequencer, the output valid and the registers to
//  their defaults; the texel store is not cleared and needs no clearing pass.
module bilinear_texture_sampler (
	input  logic                             clk,
	input  logic                             arst_n,
	// Item channel
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic                             operation,
	input  logic [bts_pkg::ADDR_IN_W-1:0]    texel_address,
	input  logic [bts_pkg::TEXEL_W-1:0]      texel_value,
	input  logic signed [bts_pkg::COORD_W-1:0] coord_u,
	input  logic signed [bts_pkg::COORD_W-1:0] coord_v,
	// Result channel
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [bts_pkg::CHAN_W-1:0]       alpha,
	output logic [bts_pkg::CHAN_W-1:0]       red,
	output logic [bts_pkg::CHAN_W-1:0]       green,
	output logic [bts_pkg::CHAN_W-1:0]       blue,
	// Configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bts_pkg::PADDR_W-1:0]      paddr,
	input  logic [bts_pkg::PDATA_W-1:0]      pwdata,
	output logic [bts_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready
);
	import bts_pkg::*;

	// Sequencer: accept, form neighbor coordinates, fetch and blend, deliver
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ADDR  = 4'b0010,
		ST_FETCH = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	logic [STEP_W-1:0] step_q;

	// Configuration registers
	logic [LOG2_W-1:0] width_log2_q;
	logic [LOG2_W-1:0] height_log2_q;
	logic              repeat_s_q;
	logic              repeat_t_q;
	logic              linear_q;
	logic              cfg_wr;
	cfg_reg_t          cfg_sel;

	// Item datapath
	logic              item_fire;
	logic signed [COORD_W-1:0] u_q;
	logic signed [COORD_W-1:0] v_q;
	logic [SIDE_LG_W-1:0] wl;
	logic [SIDE_LG_W-1:0] hl;
	logic signed [S_W-1:0] su;
	logic signed [S_W-1:0] sv;
	logic signed [S_W-1:0] sx;
	logic signed [S_W-1:0] sy;
	logic signed [NEIGH_W-1:0] x0;
	logic signed [NEIGH_W-1:0] y0;
	logic [COORD_FRAC_BITS-1:0] fx;
	logic [COORD_FRAC_BITS-1:0] fy;
	logic [SIDE_W-1:0] xa_q;
	logic [SIDE_W-1:0] xb_q;
	logic [SIDE_W-1:0] ya_q;
	logic [SIDE_W-1:0] yb_q;
	logic [WFRAC_W-1:0] fx_q;
	logic [WFRAC_W-1:0] gx_q;
	logic [WFRAC_W-1:0] fy_q;
	logic [WFRAC_W-1:0] gy_q;

	// Fetch, shared multiplier and blend lanes
	logic [TAP_W-1:0]    tap;
	logic                issue;
	logic                last_step;
	logic [SIDE_W-1:0]   rd_x;
	logic [SIDE_W-1:0]   rd_y;
	logic [STORE_AW-1:0] rd_addr;
	logic [STORE_AW-1:0] mem_addr;
	logic                mem_we;
	logic                mem_re;
	logic [TEXEL_W-1:0]  tex_mem_q [STORE_DEPTH];
	logic [TEXEL_W-1:0]  rdata_q;
	logic [WFRAC_W-1:0]  mul_a;
	logic [WFRAC_W-1:0]  mul_b;
	logic [2*WFRAC_W-1:0] mul_p;
	logic [PROD_W-1:0]   prod_q;
	logic [WT_W-1:0]     wt;
	logic [ACC_W-1:0]    acc_q [NUM_CH];
	logic [CHAN_W-1:0]   res_q [NUM_CH];
	logic [CHAN_W-1:0]   res_d [NUM_CH];
	logic                out_free;
	logic                result_valid_q;

	function automatic logic [CHAN_W-1:0] chan_of(input logic [TEXEL_W-1:0] t, input int c);
		chan_of = t[TEXEL_W - 1 - CHAN_W * c -: CHAN_W];
	endfunction

	// Drop the blend fraction and saturate at full scale
	function automatic logic [CHAN_W-1:0] sat_chan(input logic [ACC_W-1:0] a);
		logic [ACC_W-BLEND_SHIFT-1:0] s;
		s = a[ACC_W-1:BLEND_SHIFT];
		if (s > (ACC_W - BLEND_SHIFT)'({CHAN_W{1'b1}}))
			sat_chan = {CHAN_W{1'b1}};
		else
			sat_chan = s[CHAN_W-1:0];
	endfunction

	// ---------------------------------------------------------------------
	// Configuration port: zero-wait writes, combinational readback
	// ---------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_sel = cfg_reg_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_log2_q  <= RST_SIDE_LOG2;
			height_log2_q <= RST_SIDE_LOG2;
			repeat_s_q    <= 1'b1;
			repeat_t_q    <= 1'b1;
			linear_q      <= 1'b1;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_WIDTH_LOG2:  width_log2_q  <= pwdata[LOG2_W-1:0];
				REG_HEIGHT_LOG2: height_log2_q <= pwdata[LOG2_W-1:0];
				REG_REPEAT_S:    repeat_s_q    <= pwdata[0];
				REG_REPEAT_T:    repeat_t_q    <= pwdata[0];
				REG_LINEAR:      linear_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_WIDTH_LOG2:  prdata = PDATA_W'(width_log2_q);
			REG_HEIGHT_LOG2: prdata = PDATA_W'(height_log2_q);
			REG_REPEAT_S:    prdata = PDATA_W'(repeat_s_q);
			REG_REPEAT_T:    prdata = PDATA_W'(repeat_t_q);
			REG_LINEAR:      prdata = PDATA_W'(linear_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Item acceptance: take transactions only while idle
	// ---------------------------------------------------------------------
	assign item_ready = (state_q == ST_IDLE);
	assign item_fire  = item_valid & item_ready;

	// ---------------------------------------------------------------------
	// Coordinate stage: scale by the side, subtract half a texel in linear
	// mode, split into integer texel and fraction, then wrap or clamp both
	// neighbors per axis. Nearest mode uses only the first neighbor.
	// ---------------------------------------------------------------------
	assign wl = eff_log2(width_log2_q);
	assign hl = eff_log2(height_log2_q);

	always_comb begin
		su = $signed({{(S_W - COORD_W){u_q[COORD_W-1]}}, u_q}) <<< wl;
		sv = $signed({{(S_W - COORD_W){v_q[COORD_W-1]}}, v_q}) <<< hl;
		sx = linear_q ? su - $signed(HALF_TEXEL) : su;
		sy = linear_q ? sv - $signed(HALF_TEXEL) : sv;
		x0 = $signed({sx[S_W-1], sx[S_W-1:COORD_FRAC_BITS]});
		y0 = $signed({sy[S_W-1], sy[S_W-1:COORD_FRAC_BITS]});
		fx = sx[COORD_FRAC_BITS-1:0];
		fy = sy[COORD_FRAC_BITS-1:0];
	end

	// ---------------------------------------------------------------------
	// Fetch sequence: one tap per step. Tap bit 0 picks the right column
	// and the x fraction, tap bit 1 the lower row and the y fraction.
	// Step k issues read and weight product k and blends tap k-1.
	// ---------------------------------------------------------------------
	assign tap       = step_q[TAP_W-1:0];
	assign issue     = linear_q ? (step_q < STEP_W'(NUM_TAPS)) : (step_q == '0);
	assign last_step = linear_q ? (step_q == STEP_W'(NUM_TAPS)) : (step_q == STEP_W'(1));
	assign rd_x      = tap[0] ? xb_q : xa_q;
	assign rd_y      = tap[1] ? yb_q : ya_q;
	assign rd_addr   = (STORE_AW'(rd_y) << wl) | STORE_AW'(rd_x);

	// Single-port store: writes only while idle, reads only while fetching
	assign mem_we   = item_fire & (operation == OP_WRITE);
	assign mem_re   = (state_q == ST_FETCH) & issue;
	assign mem_addr = (state_q == ST_FETCH) ? rd_addr : STORE_AW'(texel_address);

	always_ff @(posedge clk) begin
		if (mem_we)
			tex_mem_q[mem_addr] <= texel_value;
	end

	always_ff @(posedge clk) begin
		if (mem_re)
			rdata_q <= tex_mem_q[mem_addr];
	end

	// Shared fraction multiplier: one weight product per step
	assign mul_a = tap[0] ? fx_q : gx_q;
	assign mul_b = tap[1] ? fy_q : gy_q;
	assign mul_p = mul_a * mul_b;
	assign wt    = round_weight(prod_q);

	assign out_free = ~result_valid_q | result_ready;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			if (linear_q)
				res_d[c] = sat_chan(acc_q[c]);
			else
				res_d[c] = chan_of(rdata_q, c);
		end
	end

	// Datapath registers, no reset
	always_ff @(posedge clk) begin
		if (item_fire && operation == OP_SAMPLE) begin
			u_q <= coord_u;
			v_q <= coord_v;
		end
		if (state_q == ST_ADDR) begin
			xa_q <= wrap_axis(x0, wl, repeat_s_q);
			xb_q <= wrap_axis(x0 + NEIGH_W'(1), wl, repeat_s_q);
			ya_q <= wrap_axis(y0, hl, repeat_t_q);
			yb_q <= wrap_axis(y0 + NEIGH_W'(1), hl, repeat_t_q);
			fx_q <= WFRAC_W'(fx);
			fy_q <= WFRAC_W'(fy);
			gx_q <= ONE_FRAC - WFRAC_W'(fx);
			gy_q <= ONE_FRAC - WFRAC_W'(fy);
			for (int c = 0; c < NUM_CH; c++)
				acc_q[c] <= '0;
		end
		if (mem_re)
			prod_q <= mul_p[PROD_W-1:0];
		// Blend the tap fetched in the previous step, one lane per channel
		if (state_q == ST_FETCH && step_q != '0) begin
			for (int c = 0; c < NUM_CH; c++)
				acc_q[c] <= acc_q[c] + ACC_W'(chan_of(rdata_q, c)) * ACC_W'(wt);
		end
		if (state_q == ST_DONE && out_free) begin
			for (int c = 0; c < NUM_CH; c++)
				res_q[c] <= res_d[c];
		end
	end

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// Raise valid as a result leaves the sequencer, drop it once taken
			if (state_q == ST_DONE && out_free)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (item_fire && operation == OP_SAMPLE)
						state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					step_q  <= '0;
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					if (last_step)
						state_q <= ST_DONE;
					else
						step_q <= step_q + STEP_W'(1);
				end
				ST_DONE: begin
					// Hold until the output register is free
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign alpha = res_q[0];
	assign red   = res_q[1];
	assign green = res_q[2];
	assign blue  = res_q[3];

endmodule

// ----- hw/rtl/bts_checker.sv -----
// Port-level checker for the texture sampler, bound to its top level.
`include "bilinear_texture_sampler_defines.svh"

module bts_port_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             item_valid,
	input logic                             item_ready,
	input logic                             operation,
	input logic                             result_valid,
	input logic                             result_ready,
	input logic [bts_pkg::CHAN_W-1:0]       alpha,
	input logic [bts_pkg::CHAN_W-1:0]       red,
	input logic [bts_pkg::CHAN_W-1:0]       green,
	input logic [bts_pkg::CHAN_W-1:0]       blue,
	input logic                             psel,
	input logic                             penable,
	input logic                             pwrite,
	input logic [bts_pkg::PADDR_W-1:0]      paddr,
	input logic [bts_pkg::PDATA_W-1:0]      pwdata,
	input logic [bts_pkg::PDATA_W-1:0]      prdata,
	input logic                             pready
);
	import bts_pkg::*;

	logic [PADDR_W-1:0] linear_addr;
	logic               cfg_wr;
	logic               item_fire;

	assign linear_addr = PADDR_W'(REG_LINEAR) << 2;
	assign cfg_wr      = psel & penable & pwrite & pready;
	assign item_fire   = item_valid & item_ready;

	// A stalled result keeps its channels
	`BTS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(alpha) && $stable(red) && $stable(green) && $stable(blue), "result changed while stalled")

	// A sample keeps the block busy for at least the next cycle
	`BTS_ASSERT_NEXT(a_sample_busy, item_fire && operation == OP_SAMPLE, !item_ready, "sampler ready right after a sample")

	// A texel write never produces a result
	`BTS_ASSERT_NEXT(a_write_silent, item_fire && operation == OP_WRITE && !result_valid, !result_valid, "result after a texel write")

	// A new result appears together with the return to idle
	`BTS_ASSERT_NOW(a_result_idle, $rose(result_valid), item_ready, "result delivered while busy")

	// The filter mode register reads back what was written
	`BTS_ASSERT_NEXT(a_linear_readback, cfg_wr && paddr == linear_addr, paddr != linear_addr || (prdata[0] == $past(pwdata[0]) && prdata[PDATA_W-1:1] == '0), "filter mode readback mismatch")

endmodule

bind bilinear_texture_sampler bts_port_checker u_bts_checker (.*);
